>>> rtl/core/humidity_temp_frame_decoder_assert.svh
// Assertion macros for the frame decoder.
// No dependencies; included by the modules that assert.
`ifndef HUMIDITY_TEMP_FRAME_DECODER_ASSERT_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HTFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define HTFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/htfd_pkg.sv
// Constants shared by the frame decoder modules.
// No dependencies.
package htfd_pkg;

   localparam logic CSR_CRC_POLY = 1'b0;
   localparam logic CSR_CRC_INIT = 1'b1;

   localparam logic [7:0] CRC_POLY_RESET = 8'h31;
   localparam logic [7:0] CRC_INIT_RESET = 8'hFF;

   localparam logic [2:0] POS_FIRST_HIGH  = 3'd0;
   localparam logic [2:0] POS_FIRST_LOW   = 3'd1;
   localparam logic [2:0] POS_FIRST_CRC   = 3'd2;
   localparam logic [2:0] POS_SECOND_HIGH = 3'd3;
   localparam logic [2:0] POS_SECOND_LOW  = 3'd4;
   localparam logic [2:0] POS_SECOND_CRC  = 3'd5;

   localparam logic [14:0] TEMP_SCALE  = 15'd17500;
   localparam logic [14:0] TEMP_OFFSET = 15'd4500;
   localparam logic [13:0] HUM_SCALE   = 14'd10000;
   localparam logic [13:0] HUM_MAX     = 14'd10000;
   localparam logic [16:0] FULL_SCALE  = 17'd65535;

endpackage

>>> rtl/core/htfd_crc8.sv
// CRC-8 update over one byte, MSB first, programmable polynomial.
// Purely combinational; no package dependencies.
module htfd_crc8 (
   input  logic [7:0] crc_seed,
   input  logic [7:0] data,
   input  logic [7:0] poly,
   output logic [7:0] crc_out
);

   always_comb begin
      logic [7:0] c;
      c = crc_seed ^ data;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ poly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      crc_out = c;
   end

endmodule

>>> rtl/core/humidity_temp_frame_decoder.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  rx_byte, frame_start, status_frame
// rsp       out        rsp_valid/rsp_stall  result_code, is_status, status_word, temp, hum
// csr       in         csr_valid/csr_ready  csr_index, csr_data
//
// One request per cycle sustained unless rsp_stall holds a pending result.
// Input register feeds CRC, word capture and scale multiply; result register follows.
// Synchronous reset clears pipeline valids and frame position and reloads CRC registers.
// rsp_stall holds the result register; the input register still takes one request.
// Depends on htfd_pkg, htfd_crc8 and humidity_temp_frame_decoder_assert.svh.
`include "humidity_temp_frame_decoder_assert.svh"

module humidity_temp_frame_decoder
   import htfd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_frame_start,
   input  logic               req_status_frame,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_result_code,
   output logic               rsp_is_status,
   output logic [15:0]        rsp_status_word,
   output logic signed [14:0] rsp_temperature_centi,
   output logic [13:0]        rsp_humidity_centi,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [7:0]         csr_data
);

   function automatic logic [14:0] div_full_scale(input logic [30:0] x);
      logic [14:0] q0;
      logic [16:0] r;
      q0 = x[30:16];
      r  = {1'b0, x[15:0]} + {2'b00, q0};
      return (r >= FULL_SCALE) ? q0 + 15'd1 : q0;
   endfunction

   logic [7:0]  poly_ff, init_ff;
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_start_ff, in_stype_ff;
   logic [2:0]  pos_ff, pos_in;
   logic [7:0]  crc_ff, crc_in;
   logic [7:0]  high_ff, high_in;
   logic [15:0] first_word_ff, first_word_in;
   logic [30:0] temp_prod_ff, temp_prod_in;
   logic [29:0] hum_prod_ff, hum_prod_in;
   logic        failed_ff, failed_in;
   logic        status_ff, status_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_code_ff, rsp_code_in;
   logic               rsp_stat_ff, rsp_stat_in;
   logic [15:0]        rsp_word_ff, rsp_word_in;
   logic signed [14:0] rsp_temp_ff, rsp_temp_in;
   logic [13:0]        rsp_hum_ff, rsp_hum_in;

   logic        advance, go, active, last, emit, status_cur, failed_cur;
   logic [2:0]  pos_cur;
   logic [7:0]  crc_seed, crc_next;
   logic [15:0] word;
   logic [14:0] temp_q, hum_q;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign go        = in_valid_ff && advance;
   assign csr_ready = 1'b1;

   assign pos_cur    = in_start_ff ? POS_FIRST_HIGH : pos_ff;
   assign active     = in_start_ff || (pos_ff != POS_FIRST_HIGH);
   assign status_cur = in_start_ff ? in_stype_ff : status_ff;
   assign failed_cur = in_start_ff ? 1'b0 : failed_ff;
   assign last       = status_cur ? (pos_cur == POS_FIRST_CRC) : (pos_cur == POS_SECOND_CRC);
   assign emit       = go && active && last;
   assign word       = {high_ff, in_byte_ff};
   assign crc_seed   = (pos_cur == POS_FIRST_HIGH || pos_cur == POS_SECOND_HIGH) ?
                       init_ff : crc_ff;

   htfd_crc8 u_crc8 (
      .crc_seed (crc_seed),
      .data     (in_byte_ff),
      .poly     (poly_ff),
      .crc_out  (crc_next)
   );

   assign temp_q = div_full_scale(temp_prod_ff);
   assign hum_q  = div_full_scale({1'b0, hum_prod_ff});

   always_comb begin
      pos_in        = pos_ff;
      crc_in        = crc_ff;
      high_in       = high_ff;
      first_word_in = first_word_ff;
      temp_prod_in  = temp_prod_ff;
      hum_prod_in   = hum_prod_ff;
      failed_in     = failed_ff;
      status_in     = status_ff;
      if (go && active) begin
         status_in = status_cur;
         failed_in = failed_cur;
         case (pos_cur)
            POS_FIRST_HIGH, POS_SECOND_HIGH: begin
               high_in = in_byte_ff;
               crc_in  = crc_next;
            end
            POS_FIRST_LOW: begin
               crc_in        = crc_next;
               first_word_in = word;
               temp_prod_in  = 31'(TEMP_SCALE) * 31'(word);
            end
            POS_SECOND_LOW: begin
               crc_in      = crc_next;
               hum_prod_in = 30'(HUM_SCALE) * 30'(word);
            end
            default: begin
               if (crc_ff != in_byte_ff) begin
                  failed_in = 1'b1;
               end
            end
         endcase
         pos_in = last ? POS_FIRST_HIGH : pos_cur + 3'd1;
      end
   end

   always_comb begin
      rsp_valid_in = advance ? emit : rsp_valid_ff;
      rsp_code_in  = failed_in;
      rsp_stat_in  = status_cur;
      rsp_word_in  = '0;
      rsp_temp_in  = '0;
      rsp_hum_in   = '0;
      if (!failed_in) begin
         if (status_cur) begin
            rsp_word_in = first_word_ff;
         end else begin
            rsp_temp_in = $signed(temp_q - TEMP_OFFSET);
            rsp_hum_in  = (hum_q > {1'b0, HUM_MAX}) ? HUM_MAX : hum_q[13:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff      <= CRC_POLY_RESET;
         init_ff      <= CRC_INIT_RESET;
         in_valid_ff  <= 1'b0;
         pos_ff       <= POS_FIRST_HIGH;
         crc_ff       <= CRC_INIT_RESET;
         failed_ff    <= 1'b0;
         status_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CRC_POLY: poly_ff <= csr_data;
               CSR_CRC_INIT: init_ff <= csr_data;
               default: ;
            endcase
         end
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         failed_ff    <= failed_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff  <= req_rx_byte;
         in_start_ff <= req_frame_start;
         in_stype_ff <= req_status_frame;
      end
      high_ff       <= high_in;
      first_word_ff <= first_word_in;
      temp_prod_ff  <= temp_prod_in;
      hum_prod_ff   <= hum_prod_in;
      if (advance && emit) begin
         rsp_code_ff <= rsp_code_in;
         rsp_stat_ff <= rsp_stat_in;
         rsp_word_ff <= rsp_word_in;
         rsp_temp_ff <= rsp_temp_in;
         rsp_hum_ff  <= rsp_hum_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_result_code       = rsp_code_ff;
   assign rsp_is_status         = rsp_stat_ff;
   assign rsp_status_word       = rsp_word_ff;
   assign rsp_temperature_centi = rsp_temp_ff;
   assign rsp_humidity_centi    = rsp_hum_ff;

   `HTFD_ASSERT_NOW(a_pos_range, clock, reset, 1'b1, pos_ff <= POS_SECOND_CRC,
      "byte position beyond measurement frame")
   `HTFD_ASSERT_NOW(a_status_pos, clock, reset, status_ff, pos_ff <= POS_FIRST_CRC,
      "status frame beyond its crc byte")
   `HTFD_ASSERT_NOW(a_stall_occupied, clock, reset, req_stall, in_valid_ff && rsp_valid_ff,
      "input stalled without a blocked result")
   `HTFD_ASSERT_NOW(a_error_zero, clock, reset, rsp_valid && rsp_result_code,
      rsp_status_word == 16'd0 && rsp_temperature_centi == 15'sd0 &&
      rsp_humidity_centi == 14'd0, "error result carries payload")
   `HTFD_ASSERT_NEXT(a_emit_resets_pos, clock, reset, emit, pos_ff == POS_FIRST_HIGH,
      "frame position not cleared after result")

endmodule

>>> bench/tb_top.sv
// Self-checking bench for humidity_temp_frame_decoder: sensor frame bytes in,
// decoded status/measurement results out, checked against an in-bench decoder.
// Depends on htfd_pkg and the decoder RTL.
module tb_top;
   import htfd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MEAS_LEN        = 6;
   localparam int STAT_LEN        = 3;
   localparam int N_DIRECTED      = 27;
   localparam int N_PHASES        = 5;
   localparam int ITEMS_PER_PHASE = 165;
   localparam int PIPE_DELAY      = 4;
   localparam int QUIET_LIMIT     = 1000;
   localparam int MAX_REPORTS     = 10;

   localparam logic RES_OK      = 1'b0;
   localparam logic RES_CRC_ERR = 1'b1;

   typedef enum logic [1:0] {CRC_AS_IS, CRC_GOOD, CRC_BAD} crc_mode_type;

   typedef struct packed {
      logic               code;
      logic               stat;
      logic [15:0]        sword;
      logic signed [14:0] temp;
      logic [13:0]        hum;
   } frame_result_type;

   typedef struct packed {
      logic [7:0]       b;
      logic             start;
      logic             stype;
      crc_mode_type     mode;
      logic             typed;
      frame_result_type res;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [7:0]         req_rx_byte;
   logic               req_frame_start;
   logic               req_status_frame;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_result_code;
   logic               rsp_is_status;
   logic [15:0]        rsp_status_word;
   logic signed [14:0] rsp_temperature_centi;
   logic [13:0]        rsp_humidity_centi;
   logic               csr_valid;
   logic               csr_ready;
   logic               csr_index;
   logic [7:0]         csr_data;

   humidity_temp_frame_decoder DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // decoder model state and its copy of the registers
   logic [7:0]  cfg_poly = CRC_POLY_RESET;
   logic [7:0]  cfg_init = CRC_INIT_RESET;
   logic [2:0]  pos      = POS_FIRST_HIGH;
   logic [7:0]  crc_run  = CRC_INIT_RESET;
   logic [7:0]  hi_hold  = '0;
   logic [15:0] word0    = '0;
   logic [15:0] word1    = '0;
   logic        failed   = 1'b0;
   logic        is_stat  = 1'b0;

   frame_result_type frame_q[$];
   stim_row_type     dir_rows[N_DIRECTED];
   int               mismatches = 0;
   int               items_done = 0;
   int               quiet      = 0;
   int               stall_left = 0;
   bit               gaps_on    = 1'b1;

   function automatic logic [7:0] crc8_next(logic [7:0] crc, logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++)
         c = c[7] ? ((c << 1) ^ cfg_poly) : (c << 1);
      return c;
   endfunction

   function automatic bit decode_byte(input logic [7:0] b, input logic start,
                                      input logic stype, output frame_result_type r);
      logic [2:0] k;
      logic [2:0] last;
      longint     tc;
      longint     h;
      r = '0;
      if (start) begin
         pos     = POS_FIRST_HIGH;
         is_stat = stype;
         failed  = 1'b0;
      end else if (pos == POS_FIRST_HIGH) begin
         return 1'b0;
      end
      k = pos;
      case (k)
         POS_FIRST_HIGH, POS_SECOND_HIGH: begin
            hi_hold = b;
            crc_run = crc8_next(cfg_init, b);
         end
         POS_FIRST_LOW, POS_SECOND_LOW: begin
            crc_run = crc8_next(crc_run, b);
            if (k == POS_FIRST_LOW) word0 = {hi_hold, b};
            else word1 = {hi_hold, b};
         end
         default: begin
            if (crc_run != b) failed = 1'b1;
         end
      endcase
      last = is_stat ? POS_FIRST_CRC : POS_SECOND_CRC;
      if (k != last) begin
         pos = k + 3'd1;
         return 1'b0;
      end
      pos    = POS_FIRST_HIGH;
      r.code = failed ? RES_CRC_ERR : RES_OK;
      r.stat = is_stat;
      if (!failed) begin
         if (is_stat) begin
            r.sword = word0;
         end else begin
            tc     = (17500 * longint'(word0)) / 65535 - 4500;
            h      = (10000 * longint'(word1)) / 65535;
            if (h > 10000) h = 10000;
            r.temp = tc[14:0];
            r.hum  = h[13:0];
         end
      end
      return 1'b1;
   endfunction

   function automatic stim_row_type mk_row(logic [7:0] b, logic st, logic sf,
                                           crc_mode_type m, logic typed, logic code,
                                           logic stat, logic [15:0] sw, int temp, int hum);
      stim_row_type row;
      row.b         = b;
      row.start     = st;
      row.stype     = sf;
      row.mode      = m;
      row.typed     = typed;
      row.res.code  = code;
      row.res.stat  = stat;
      row.res.sword = sw;
      row.res.temp  = temp[14:0];
      row.res.hum   = hum[13:0];
      return row;
   endfunction

   initial begin
      // byte while idle, ignored
      dir_rows[0]  = mk_row(8'h5A, 1, 0, CRC_AS_IS, 0, 0, 0, 0, 0, 0);
      dir_rows[0].start = 1'b0;
      dir_rows[0].stype = 1'b1;
      // status frame; type input toggles mid-frame
      dir_rows[1]  = mk_row(8'hBE, 1, 1, CRC_AS_IS, 0, 0, 0, 0, 0, 0);
      dir_rows[2]  = mk_row(8'hEF, 0, 0, CRC_AS_IS, 0, 0, 0, 0, 0, 0);
      dir_rows[3]  = mk_row(8'h00, 0, 0, CRC_GOOD, 1, RES_OK, 1, 16'hBEEF, 0, 0);
      // measurement, raw zero
      dir_rows[4]  = mk_row(8'h00, 1, 0, CRC_AS_IS, 0, 0, 0, 0, 0, 0);
      dir_rows[5]  = mk_row(8'h00, 0, 1, CRC_AS_IS, 0, 0, 0, 0, 0, 0);
      dir_rows[6]  = mk_row(8'h00, 0, 0, CRC_GOOD, 0, 0, 0, 0, 0, 0);
      dir_rows[7]  = mk_row(8'h00, 0, 0, CRC_AS_IS, 0, 0, 0, 0, 0, 0);
      dir_rows[8]  = mk_row(8'h00, 0, 0, CRC_AS_IS, 0, 0, 0, 0, 0, 0);
      dir_rows[9]  = mk_row(8'h00, 0, 0, CRC_GOOD, 1, RES_OK, 0, 0, -4500, 0);
      // measurement, raw full scale
      dir_rows[10] = mk_row(8'hFF, 1, 0, CRC_AS_IS, 0, 0, 0, 0, 0, 0);
      dir_rows[11] = mk_row(8'hFF, 0, 0, CRC_AS_IS, 0, 0, 0, 0, 0, 0);
      dir_rows[12] = mk_row(8'h00, 0, 0, CRC_GOOD, 0, 0, 0, 0, 0, 0);
      dir_rows[13] = mk_row(8'hFF, 0, 0, CRC_AS_IS, 0, 0, 0, 0, 0, 0);
      dir_rows[14] = mk_row(8'hFF, 0, 0, CRC_AS_IS, 0, 0, 0, 0, 0, 0);
      dir_rows[15] = mk_row(8'h00, 0, 0, CRC_GOOD, 1, RES_OK, 0, 0, 13000, 10000);
      // humidity word fails its check
      dir_rows[16] = mk_row(8'h80, 1, 0, CRC_AS_IS, 0, 0, 0, 0, 0, 0);
      dir_rows[17] = mk_row(8'h00, 0, 0, CRC_AS_IS, 0, 0, 0, 0, 0, 0);
      dir_rows[18] = mk_row(8'h00, 0, 0, CRC_GOOD, 0, 0, 0, 0, 0, 0);
      dir_rows[19] = mk_row(8'hFF, 0, 0, CRC_AS_IS, 0, 0, 0, 0, 0, 0);
      dir_rows[20] = mk_row(8'hFF, 0, 0, CRC_AS_IS, 0, 0, 0, 0, 0, 0);
      dir_rows[21] = mk_row(8'h00, 0, 0, CRC_BAD, 1, RES_CRC_ERR, 0, 0, 0, 0);
      // partial frame dropped by a new start
      dir_rows[22] = mk_row(8'h55, 1, 0, CRC_AS_IS, 0, 0, 0, 0, 0, 0);
      dir_rows[23] = mk_row(8'hAA, 0, 0, CRC_AS_IS, 0, 0, 0, 0, 0, 0);
      dir_rows[24] = mk_row(8'h12, 1, 1, CRC_AS_IS, 0, 0, 0, 0, 0, 0);
      dir_rows[25] = mk_row(8'h34, 0, 0, CRC_AS_IS, 0, 0, 0, 0, 0, 0);
      dir_rows[26] = mk_row(8'h00, 0, 1, CRC_GOOD, 0, 0, 0, 0, 0, 0);
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_byte(input logic [7:0] b, input logic start, input logic stype,
                            input crc_mode_type mode, input logic typed,
                            input frame_result_type fixed);
      frame_result_type pred;
      logic [7:0]       data;
      bit               produced;
      data = b;
      if (mode == CRC_GOOD) data = crc_run;
      else if (mode == CRC_BAD) data = crc_run ^ 8'($urandom_range(1, 255));
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid        = 1'b1;
      req_rx_byte      = data;
      req_frame_start  = start;
      req_status_frame = stype;
      do @(posedge clock); while (req_stall);
      if (start || pos != POS_FIRST_HIGH) items_done++;
      produced = decode_byte(data, start, stype, pred);
      if (typed) frame_q.push_back(fixed);
      else if (produced) frame_q.push_back(pred);
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic send_frame();
      int           kind;
      int           nbytes;
      logic         stype;
      logic [15:0]  w0;
      logic [15:0]  w1;
      logic [7:0]   b;
      crc_mode_type mode;
      kind = $urandom_range(0, 19);
      if (kind < 2) begin
         send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
                   CRC_AS_IS, 1'b0, '0);
         return;
      end
      stype  = 1'($urandom_range(0, 1));
      nbytes = stype ? STAT_LEN : MEAS_LEN;
      if (kind < 4) nbytes = $urandom_range(1, nbytes - 1);
      w0 = pick_word();
      w1 = pick_word();
      for (int i = 0; i < nbytes; i++) begin
         mode = CRC_AS_IS;
         case (i)
            0: b = w0[15:8];
            1: b = w0[7:0];
            3: b = w1[15:8];
            4: b = w1[7:0];
            default: begin
               b    = 8'h00;
               mode = ($urandom_range(0, 7) == 0) ? CRC_BAD : CRC_GOOD;
            end
         endcase
         send_byte(b, i == 0, (i == 0) ? stype : 1'($urandom_range(0, 1)), mode, 1'b0, '0);
      end
   endtask

   // waits out the pipeline, then writes one register
   task automatic write_csr(input logic idx, input logic [7:0] value);
      while (frame_q.size() != 0) @(negedge clock);
      repeat (PIPE_DELAY) @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_CRC_POLY) cfg_poly = value;
      else cfg_init = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   always @(negedge clock) begin
      if (!gaps_on) begin
         stall_left = 0;
         rsp_stall  = 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_stall = 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 9);
         rsp_stall  = 1'b1;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   always @(posedge clock) begin
      frame_result_type got;
      frame_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.code  = rsp_result_code;
         got.stat  = rsp_is_status;
         got.sword = rsp_status_word;
         got.temp  = rsp_temperature_centi;
         got.hum   = rsp_humidity_centi;
         if (frame_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: result with none expected: code=%0d status=%0d word=%h %s%0d %s%0d",
                        $realtime, got.code, got.stat, got.sword, "temp=", got.temp,
                        "hum=", got.hum);
         end else begin
            want = frame_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("%0t: mismatch exp code=%0d status=%0d word=%h temp=%0d hum=%0d,",
                           $realtime, want.code, want.stat, want.sword, want.temp, want.hum);
                  $display("   got code=%0d status=%0d word=%h temp=%0d hum=%0d",
                           got.code, got.stat, got.sword, got.temp, got.hum);
               end
            end
         end
      end
   end

   // watchdog: ends the run after a long stretch with no handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet = 0;
      else
         quiet++;
      if (quiet >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      logic [7:0] poly_set [N_PHASES];
      logic [7:0] init_set [N_PHASES];
      poly_set = '{CRC_POLY_RESET, 8'h00, 8'hFF, 8'($urandom_range(0, 255)), CRC_POLY_RESET};
      init_set = '{CRC_INIT_RESET, 8'h00, 8'hFF, 8'($urandom_range(0, 255)), CRC_INIT_RESET};
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_rx_byte      = '0;
      req_frame_start  = 1'b0;
      req_status_frame = 1'b0;
      csr_valid        = 1'b0;
      csr_index        = CSR_CRC_POLY;
      csr_data         = '0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < N_DIRECTED; i++)
         send_byte(dir_rows[i].b, dir_rows[i].start, dir_rows[i].stype, dir_rows[i].mode,
                   dir_rows[i].typed, dir_rows[i].res);
      req_valid = 1'b0;

      for (int p = 0; p < N_PHASES; p++) begin
         req_valid = 1'b0;
         write_csr(CSR_CRC_POLY, poly_set[p]);
         write_csr(CSR_CRC_INIT, init_set[p]);
         items_done = 0;
         while (items_done < ITEMS_PER_PHASE) begin
            gaps_on = (p != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
            send_frame();
         end
      end
      req_valid = 1'b0;
      gaps_on   = 1'b0;

      while (frame_q.size() != 0) @(negedge clock);
      repeat (2 * PIPE_DELAY) @(negedge clock);
      if (mismatches == 0 && frame_q.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/htfd_pkg.sv
rtl/core/htfd_crc8.sv
rtl/core/humidity_temp_frame_decoder.sv
bench/tb_top.sv
